/* sv/ctvs_pkg.sv */
`default_nettype none
package ctvs_pkg;

   // store geometry
   localparam int MAX_ENTRIES = 256;
   localparam int MAX_DIM     = 256;
   localparam int TOP_K_MAX   = 16;

   localparam int IDX_W  = $clog2(MAX_ENTRIES);      // entry address
   localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);  // entry count
   localparam int ADR_W  = $clog2(MAX_DIM);          // element address
   localparam int POS_W  = $clog2(MAX_DIM + 1);      // element count
   localparam int K_W    = $clog2(TOP_K_MAX + 1);    // hit count
   localparam int RANK_W = $clog2(TOP_K_MAX);

   // arithmetic widths
   localparam int ELEM_W = 16;
   localparam int PROD_W = 2 * ELEM_W - 1;           // |a*b| <= 2^30
   localparam int ACC_W  = PROD_W + ADR_W;           // norm and |dot| magnitude
   localparam int MUL_W  = 2 * ACC_W;                // na*nb, dot^2
   localparam int M_W    = 16;                       // score magnitude bits
   localparam int SQ_W   = MUL_W + 2 * (M_W - 1) + 3;
   localparam int MC_W   = $clog2(ACC_W + 1);
   localparam int B_W    = $clog2(M_W);

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_ENTRY = 2'd1,
      OP_QUERY = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      KIND_HIT     = 3'd0,
      KIND_ADDED   = 3'd1,
      KIND_FULL    = 3'd2,
      KIND_CLEARED = 3'd3,
      KIND_NO_HITS = 3'd4
   } kind_type;

   typedef struct packed {
      logic [1:0]         op;
      logic signed [15:0] value;
      logic               last;
      logic               empty_req;
   } req_type;

   typedef struct packed {
      logic [2:0]         kind;
      logic [7:0]         entry_index;
      logic signed [15:0] score;
      logic [3:0]         rank;
      logic               last_res;
   } rsp_type;

endpackage
`default_nettype wire

/* sv/cosine_topk_vector_search.sv */
`default_nettype none
// Element words (entry or query) are written to memory at the accepting edge; clear and
// entry-end words answer in the output register at the accepting edge.
// A query end word scans every entry: the length lookup, then for an entry of matching
// length the dot/norm streaming from the element memory, the shift-add products and
// the bit-serial score search, and finally the insertion.
// Hits then leave one per cycle while the receiver is ready. Synchronous active-high
// reset empties the store and sets top_k to 1; the memories are not cleared.
module cosine_topk_vector_search (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_ready,
   input  wire ctvs_pkg::req_type   req_word,
   output logic                     rsp_valid,
   input  wire                      rsp_ready,
   output ctvs_pkg::rsp_type        rsp_word,
   input  wire                      csr_wr_en,
   input  wire [4:0]                csr_wr_data
);
   import ctvs_pkg::*;

   localparam int ENT_DEPTH = MAX_ENTRIES * MAX_DIM;

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_LEN   = 10'b0000000010,
      S_CHK   = 10'b0000000100,
      S_DOT   = 10'b0000001000,
      S_DRAIN = 10'b0000010000,
      S_MUL   = 10'b0000100000,
      S_SQA   = 10'b0001000000,
      S_SQB   = 10'b0010000000,
      S_INS   = 10'b0100000000,
      S_EMIT  = 10'b1000000000
   } state_type;

   // memories
   logic signed [ELEM_W-1:0] ent_mem [ENT_DEPTH];
   logic signed [ELEM_W-1:0] qry_mem [MAX_DIM];
   logic [POS_W-1:0]         len_mem [MAX_ENTRIES];

   state_type state_ff;
   logic [4:0]       topk_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [POS_W-1:0] pos_ff;
   logic [1:0]       lop_ff;
   logic [POS_W-1:0] qlen_ff;
   logic [K_W-1:0]   k_ff, n_ff, r_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [POS_W-1:0] j_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;

   // scan datapath
   logic signed [ELEM_W-1:0] q_rd_ff, e_rd_ff;
   logic [POS_W-1:0]         len_rd_ff;
   logic                     rd_vld_ff, prod_vld_ff;
   logic signed [31:0]       pd_ff;
   logic [PROD_W-1:0]        pa_ff, pb_ff;
   logic signed [ACC_W:0]    dot_ff;
   logic [ACC_W-1:0]         na_ff, nb_ff;
   logic [MUL_W-1:0]         ma_ff, mq_ff, p_ff, q_ff;
   logic [ACC_W-1:0]         mbn_ff, mbq_ff;
   logic [MC_W-1:0]          mc_ff;
   logic [SQ_W-1:0]          r_sq_ff, t_ff, us_ff, pb_sq_ff, trial_ff;
   logic [M_W-1:0]           m_ff;
   logic [B_W-1:0]           b_ff;
   logic                     neg_ff;
   logic signed [15:0]       score_ff;

   logic signed [15:0] best_s_ff [TOP_K_MAX];
   logic [IDX_W-1:0]   best_i_ff [TOP_K_MAX];

   // input decode
   req_type          rq;
   logic             acc, out_free, same_op, do_wr;
   logic [POS_W-1:0] pos_eff, pos_in;
   logic [CNT_W-1:0] k_full;
   logic             ent_wr, qry_wr;
   logic             rsp_load;

   assign rq        = req_word;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign acc       = req_valid && req_ready;
   assign same_op   = (lop_ff == rq.op);
   assign pos_eff   = same_op ? pos_ff : '0;
   assign do_wr     = !rq.empty_req && (pos_eff < POS_W'(MAX_DIM));
   assign pos_in    = pos_eff + POS_W'(do_wr);
   assign ent_wr    = acc && (rq.op == OP_ENTRY) && do_wr && (cnt_ff < CNT_W'(MAX_ENTRIES));
   assign qry_wr    = acc && (rq.op == OP_QUERY) && do_wr;

   // effective hit count: min(top_k, TOP_K_MAX, entry count)
   always_comb begin
      k_full = CNT_W'(topk_ff);
      if (k_full > CNT_W'(TOP_K_MAX)) k_full = CNT_W'(TOP_K_MAX);
      if (k_full > cnt_ff) k_full = cnt_ff;
   end

   // a result word is loaded into the output register
   assign rsp_load = (acc && (rq.op == OP_CLEAR ||
                      (rq.last && rq.op == OP_ENTRY && pos_in != '0) ||
                      (rq.last && rq.op == OP_QUERY && (k_full == '0 || pos_in == '0)))) ||
                     (state_ff == S_EMIT && out_free);

   // element store
   always_ff @(posedge clock) begin
      if (ent_wr) ent_mem[{cnt_ff[IDX_W-1:0], pos_eff[ADR_W-1:0]}] <= rq.value;
      e_rd_ff <= ent_mem[{idx_ff, j_ff[ADR_W-1:0]}];
   end

   // query buffer
   always_ff @(posedge clock) begin
      if (qry_wr) qry_mem[pos_eff[ADR_W-1:0]] <= rq.value;
      q_rd_ff <= qry_mem[j_ff[ADR_W-1:0]];
   end

   // entry lengths
   always_ff @(posedge clock) begin
      if (acc && rq.op == OP_ENTRY && rq.last && pos_in != '0 &&
          cnt_ff < CNT_W'(MAX_ENTRIES))
         len_mem[cnt_ff[IDX_W-1:0]] <= pos_in;
      len_rd_ff <= len_mem[idx_ff];
   end

   // products and sums
   logic signed [31:0]    prod_ab, prod_aa, prod_bb;
   logic signed [ACC_W:0] dot_abs;
   assign prod_ab = q_rd_ff * e_rd_ff;
   assign prod_aa = q_rd_ff * q_rd_ff;
   assign prod_bb = e_rd_ff * e_rd_ff;
   assign dot_abs = dot_ff[ACC_W] ? -dot_ff : dot_ff;

   // bit-serial score step
   logic             take;
   logic [M_W-1:0]   m_nx;
   logic signed [15:0] score_nx;
   always_comb begin
      take = (trial_ff <= r_sq_ff);
      m_nx = m_ff;
      if (take) m_nx[b_ff] = 1'b1;
      if (neg_ff)        score_nx = -$signed(m_nx);
      else if (m_nx[M_W-1]) score_nx = 16'sd32767;
      else               score_nx = $signed(m_nx);
   end

   // top-k insertion: list is descending, so the greater-than mask is a suffix
   logic [TOP_K_MAX-1:0] ins;
   logic                 allow;
   always_comb begin
      for (int j = 0; j < TOP_K_MAX; j++)
         ins[j] = (K_W'(j) < n_ff) ? (score_ff > best_s_ff[j]) : 1'b1;
      allow = ins[RANK_W'(k_ff - K_W'(1))];
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_INS && allow) begin
         for (int j = 0; j < TOP_K_MAX; j++) begin
            if (ins[j]) begin
               if (j == 0 || !ins[(j == 0) ? 0 : j - 1]) begin
                  best_s_ff[j] <= score_ff;
                  best_i_ff[j] <= idx_ff;
               end else begin
                  best_s_ff[j] <= best_s_ff[(j == 0) ? 0 : j - 1];
                  best_i_ff[j] <= best_i_ff[(j == 0) ? 0 : j - 1];
               end
            end
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      pd_ff <= prod_ab;
      pa_ff <= prod_aa[PROD_W-1:0];
      pb_ff <= prod_bb[PROD_W-1:0];
      case (state_ff)
         S_CHK: begin
            dot_ff <= '0;
            na_ff  <= '0;
            nb_ff  <= '0;
         end
         S_DOT, S_DRAIN: begin
            if (prod_vld_ff) begin
               dot_ff <= dot_ff + (ACC_W+1)'(pd_ff);
               na_ff  <= na_ff + ACC_W'(pa_ff);
               nb_ff  <= nb_ff + ACC_W'(pb_ff);
            end
            ma_ff  <= MUL_W'(na_ff);
            mbn_ff <= nb_ff;
            mq_ff  <= MUL_W'(dot_abs[ACC_W-1:0]);
            mbq_ff <= dot_abs[ACC_W-1:0];
            neg_ff <= dot_ff[ACC_W];
            p_ff   <= '0;
            q_ff   <= '0;
            mc_ff  <= '0;
         end
         S_MUL: begin
            if (mbn_ff[0]) p_ff <= p_ff + ma_ff;
            if (mbq_ff[0]) q_ff <= q_ff + mq_ff;
            ma_ff  <= ma_ff << 1;
            mq_ff  <= mq_ff << 1;
            mbn_ff <= mbn_ff >> 1;
            mbq_ff <= mbq_ff >> 1;
            mc_ff  <= mc_ff + MC_W'(1);
            r_sq_ff  <= SQ_W'(q_ff) << (2 * (M_W - 1));
            pb_sq_ff <= SQ_W'(p_ff) << (2 * (M_W - 1));
            t_ff  <= '0;
            us_ff <= '0;
            m_ff  <= '0;
            b_ff  <= B_W'(M_W - 1);
         end
         S_SQA: begin
            trial_ff <= t_ff + us_ff + pb_sq_ff;
         end
         S_SQB: begin
            if (take) t_ff <= trial_ff;
            us_ff    <= (us_ff >> 1) + (take ? pb_sq_ff : '0);
            pb_sq_ff <= pb_sq_ff >> 2;
            m_ff     <= m_nx;
            b_ff     <= b_ff - B_W'(1);
         end
         default: begin
         end
      endcase
      if (state_ff == S_SQB && b_ff == '0) score_ff <= score_nx;
      else if (state_ff == S_CHK || state_ff == S_DRAIN) score_ff <= '0;
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         topk_ff      <= 5'd1;
         cnt_ff       <= '0;
         pos_ff       <= '0;
         lop_ff       <= OP_CLEAR;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
         prod_vld_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) topk_ff <= csr_wr_data;
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         prod_vld_ff <= rd_vld_ff;
         rd_vld_ff   <= (state_ff == S_DOT);

         case (state_ff)
            S_IDLE: begin
               if (acc && rq.op == OP_CLEAR) begin
                  cnt_ff       <= '0;
                  pos_ff       <= '0;
                  lop_ff       <= OP_CLEAR;
                  rsp_ff       <= '{KIND_CLEARED, 8'd0, 16'sd0, 4'd0, 1'b1};
               end else if (acc && (rq.op == OP_ENTRY || rq.op == OP_QUERY)) begin
                  if (!rq.last) begin
                     pos_ff <= pos_in;
                     lop_ff <= rq.op;
                  end else begin
                     pos_ff <= '0;
                     lop_ff <= OP_CLEAR;
                     if (rq.op == OP_ENTRY) begin
                        if (pos_in != '0) begin
                           if (cnt_ff >= CNT_W'(MAX_ENTRIES)) begin
                              rsp_ff <= '{KIND_FULL, 8'd0, 16'sd0, 4'd0, 1'b1};
                           end else begin
                              rsp_ff <= '{KIND_ADDED, 8'(cnt_ff), 16'sd0, 4'd0, 1'b1};
                              cnt_ff <= cnt_ff + CNT_W'(1);
                           end
                        end
                     end else begin
                        qlen_ff <= pos_in;
                        k_ff    <= K_W'(k_full);
                        n_ff    <= '0;
                        idx_ff  <= '0;
                        if (k_full == '0 || pos_in == '0) begin
                           rsp_ff       <= '{KIND_NO_HITS, 8'd0, 16'sd0, 4'd0, 1'b1};
                        end else begin
                           state_ff <= S_LEN;
                        end
                     end
                  end
               end
            end
            S_LEN: state_ff <= S_CHK;
            S_CHK: begin
               j_ff <= '0;
               if (len_rd_ff == qlen_ff) state_ff <= S_DOT;
               else state_ff <= S_INS;
            end
            S_DOT: begin
               j_ff <= j_ff + POS_W'(1);
               if (j_ff == qlen_ff - POS_W'(1)) state_ff <= S_DRAIN;
            end
            S_DRAIN: begin
               if (!rd_vld_ff && !prod_vld_ff) begin
                  if (na_ff == '0 || nb_ff == '0) state_ff <= S_INS;
                  else state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               if (mc_ff == MC_W'(ACC_W)) state_ff <= S_SQA;
            end
            S_SQA: state_ff <= S_SQB;
            S_SQB: begin
               if (b_ff == '0) state_ff <= S_INS;
               else state_ff <= S_SQA;
            end
            S_INS: begin
               if (allow && n_ff < k_ff) n_ff <= n_ff + K_W'(1);
               idx_ff <= idx_ff + IDX_W'(1);
               r_ff   <= '0;
               if (CNT_W'(idx_ff) + CNT_W'(1) == cnt_ff) state_ff <= S_EMIT;
               else state_ff <= S_LEN;
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_ff.kind        <= KIND_HIT;
                  rsp_ff.entry_index <= 8'(best_i_ff[RANK_W'(r_ff)]);
                  rsp_ff.score       <= best_s_ff[RANK_W'(r_ff)];
                  rsp_ff.rank        <= 4'(r_ff);
                  rsp_ff.last_res    <= (r_ff + K_W'(1) == n_ff);
                  r_ff               <= r_ff + K_W'(1);
                  if (r_ff + K_W'(1) == n_ff) state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule
`default_nettype wire

/* tb/sv/ctvs_checker.sv */
`default_nettype none
module ctvs_checker (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   input  wire                    req_ready,
   input  wire ctvs_pkg::req_type req_word,
   input  wire                    rsp_valid,
   input  wire                    rsp_ready,
   input  wire ctvs_pkg::rsp_type rsp_word,
   input  wire                    csr_wr_en,
   input  wire [4:0]              csr_wr_data,
   output int                     errors,
   output int                     outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import ctvs_pkg::*;

   // shadow copy of the search store
   logic signed [15:0] vec_mem [MAX_ENTRIES][MAX_DIM];
   int unsigned        vec_len [MAX_ENTRIES];
   logic signed [15:0] probe_vec [MAX_DIM];
   int unsigned        stored;
   int unsigned        fill_pos;
   logic [1:0]         open_op;
   logic [4:0]         k_reg;

   rsp_type due_words[$];

   initial begin
      errors = 0;
      outstanding = 0;
   end

   task automatic report(input string what, input int got, input int want);
      $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
      errors++;
   endtask

   task automatic due(input kind_type kind, input int idx, input int score,
                      input int rnk, input bit fin);
      rsp_type r;
      r.kind        = kind;
      r.entry_index = idx[7:0];
      r.score       = score[15:0];
      r.rank        = rnk[3:0];
      r.last_res    = fin;
      due_words = {due_words, r};
   endtask

   // truncated 32768*cos, negative side unsaturated, positive side capped
   function automatic int cosine_q15(input int unsigned idx, input int unsigned len);
      longint          dot;
      longint unsigned na, nb, mag;
      logic [127:0]    rhs, nanb, lhs;
      int              lo, hi, m, a, b;
      dot = 0;
      na  = 0;
      nb  = 0;
      for (int i = 0; i < len; i++) begin
         a = probe_vec[i];
         b = vec_mem[idx][i];
         dot += longint'(a * b);
         na  += longint'(a * a);
         nb  += longint'(b * b);
      end
      if (na == 0 || nb == 0) return 0;
      mag  = dot < 0 ? longint'(-dot) : longint'(dot);
      rhs  = (128'(mag) * 128'(mag)) << 30;
      nanb = 128'(na) * 128'(nb);
      lo = 0;
      hi = 32768;
      while (lo < hi) begin
         m   = (lo + hi + 1) / 2;
         lhs = nanb * 128'(m * m);
         if (lhs <= rhs) lo = m;
         else hi = m - 1;
      end
      if (dot < 0) return -lo;
      return lo > 32767 ? 32767 : lo;
   endfunction

   // score every stored vector and keep the best k, lower index wins ties
   task automatic rank_query(input int unsigned qlen);
      int unsigned k, n, p;
      int          s;
      int          best_s [TOP_K_MAX];
      int          best_i [TOP_K_MAX];
      k = k_reg;
      if (k > TOP_K_MAX) k = TOP_K_MAX;
      if (k > stored) k = stored;
      if (k == 0 || qlen == 0) begin
         due(KIND_NO_HITS, 0, 0, 0, 1'b1);
         return;
      end
      n = 0;
      for (int i = 0; i < stored; i++) begin
         s = (vec_len[i] == qlen) ? cosine_q15(i, qlen) : 0;
         p = n;
         for (int j = 0; j < n; j++)
            if (s > best_s[j]) begin
               p = j;
               break;
            end
         if (p < k) begin
            if (n < k) n++;
            for (int j = n - 1; j > p; j--) begin
               best_s[j] = best_s[j-1];
               best_i[j] = best_i[j-1];
            end
            best_s[p] = s;
            best_i[p] = i;
         end
      end
      for (int j = 0; j < n; j++)
         due(KIND_HIT, best_i[j], best_s[j], j, j + 1 == n);
   endtask

   // one accepted request word
   task automatic predict_word(input req_type w);
      int unsigned len;
      if (w.op == OP_NONE) return;
      if (w.op == OP_CLEAR) begin
         stored   = 0;
         fill_pos = 0;
         open_op  = OP_CLEAR;
         due(KIND_CLEARED, 0, 0, 0, 1'b1);
         return;
      end
      if (open_op != w.op) begin
         fill_pos = 0;
         open_op  = w.op;
      end
      if (!w.empty_req && fill_pos < MAX_DIM) begin
         if (w.op == OP_QUERY) probe_vec[fill_pos] = w.value;
         else if (stored < MAX_ENTRIES) vec_mem[stored][fill_pos] = w.value;
         fill_pos++;
      end
      if (!w.last) return;
      len      = fill_pos;
      fill_pos = 0;
      open_op  = OP_CLEAR;
      if (w.op == OP_QUERY) rank_query(len);
      else if (len != 0) begin
         if (stored >= MAX_ENTRIES) due(KIND_FULL, 0, 0, 0, 1'b1);
         else begin
            vec_len[stored] = len;
            due(KIND_ADDED, stored, 0, 0, 1'b1);
            stored++;
         end
      end
   endtask

   // compare first, then predict: a word's answers never leave on its own edge
   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         stored   = 0;
         fill_pos = 0;
         open_op  = OP_CLEAR;
         k_reg    = 5'd1;
         due_words.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_words.size() == 0) begin
               report("unexpected word kind", rsp_word.kind, -1);
            end else begin
               e = due_words.pop_front();
               if (rsp_word.kind !== e.kind) report("kind", rsp_word.kind, e.kind);
               if (rsp_word.entry_index !== e.entry_index)
                  report("entry_index", rsp_word.entry_index, e.entry_index);
               if (rsp_word.score !== e.score) report("score", rsp_word.score, e.score);
               if (rsp_word.rank !== e.rank) report("rank", rsp_word.rank, e.rank);
               if (rsp_word.last_res !== e.last_res)
                  report("last_res", rsp_word.last_res, e.last_res);
            end
         end
         if (csr_wr_en) k_reg = csr_wr_data;
         if (req_valid && req_ready) predict_word(req_word);
      end
      outstanding <= due_words.size();
   end

endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import ctvs_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_word = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_word;
   logic    csr_wr_en = 1'b0;
   logic [4:0] csr_wr_data = '0;
   int      errors, outstanding;

   // stimulus-side knobs
   bit      calm = 1'b0;
   int      hold_asks = 0;
   int      hold_seen = 0;
   int      hold_left = 0;
   int      sent = 0;
   int      stored = 0;
   logic [15:0] saved_vec [300];
   int      saved_len = 0;

   cosine_topk_vector_search dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_word   (req_word),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_word   (rsp_word),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   ctvs_checker chk (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_word   (req_word),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_word   (rsp_word),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .errors     (errors),
      .outstanding(outstanding)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // safety net
   initial begin
      #20ms;
      $display("RESULT: ERROR");
      $finish;
   end

   // receiver: random stalls plus an occasional long hold-off
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_seen != hold_asks) begin
         hold_seen <= hold_asks;
         hold_left <= 400;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || $urandom_range(99) >= 15;
      end
   end

   // one request word; returns at the accepting edge
   task automatic send_word(input op_type op, input logic [15:0] v, input logic lst,
                            input logic emp);
      if (!calm && $urandom_range(99) < 15) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= '{op: op, value: v, last: lst, empty_req: emp};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
   endtask

   // mode: 0 full range, 1 small, 2 copy of saved, 3 negated saved, 4 zeros
   task automatic send_vec(input op_type op, input int len, input int mode);
      logic [15:0] v;
      bit          tail_empty;
      if (len == 0) begin
         send_word(op, 16'($urandom), 1'b1, 1'b1);
         return;
      end
      tail_empty = $urandom_range(9) == 0;
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(99) < 8) send_word(op, 16'($urandom), 1'b0, 1'b1);
         case (mode)
            0: v = 16'($urandom);
            1: v = 16'($urandom_range(16)) - 16'd8;
            2: v = i < saved_len ? saved_vec[i] : 16'($urandom);
            3: v = i < saved_len ? -saved_vec[i] : 16'($urandom);
            default: v = '0;
         endcase
         if (op == OP_ENTRY && mode < 2 && i < 300) saved_vec[i] = v;
         send_word(op, v, i == len - 1 && !tail_empty, 1'b0);
      end
      if (tail_empty) send_word(op, 16'($urandom), 1'b1, 1'b1);
      if (op == OP_ENTRY) begin
         if (mode < 2) saved_len = len;
         stored++;
      end
   endtask

   // register write once the block has drained
   task automatic write_top_k(input logic [4:0] k);
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= k;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic clear_store();
      send_word(OP_CLEAR, 16'($urandom), 1'($urandom), 1'($urandom));
      stored = 0;
   endtask

   int start_cnt, len, pick, drain;
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty store, extremes, empty vector, kind switch, idle op
      send_vec(OP_QUERY, 1, 0);
      send_word(OP_ENTRY, 16'h7fff, 1'b0, 1'b0);
      send_word(OP_ENTRY, 16'h8000, 1'b1, 1'b0);
      send_word(OP_ENTRY, 16'h0000, 1'b0, 1'b0);
      send_word(OP_ENTRY, 16'h0000, 1'b1, 1'b0);
      send_word(OP_ENTRY, 16'hffff, 1'b1, 1'b1);
      send_word(OP_ENTRY, 16'h1234, 1'b0, 1'b0);
      send_word(OP_QUERY, 16'h7fff, 1'b0, 1'b0);
      send_word(OP_QUERY, 16'h8000, 1'b1, 1'b0);
      send_word(OP_QUERY, 16'h8000, 1'b0, 1'b0);
      send_word(OP_QUERY, 16'h7fff, 1'b1, 1'b0);
      send_word(OP_NONE, 16'hffff, 1'b1, 1'b0);
      send_word(OP_QUERY, 16'h0000, 1'b1, 1'b1);
      send_word(OP_QUERY, 16'h0000, 1'b0, 1'b0);
      send_word(OP_QUERY, 16'h0000, 1'b1, 1'b0);
      write_top_k(5'd16);
      send_word(OP_QUERY, 16'h0001, 1'b0, 1'b0);
      send_word(OP_QUERY, 16'hffff, 1'b1, 1'b0);
      write_top_k(5'd0);
      send_word(OP_QUERY, 16'h0100, 1'b1, 1'b0);
      write_top_k(5'd31);
      send_word(OP_QUERY, 16'h0100, 1'b1, 1'b0);
      clear_store();
      send_word(OP_QUERY, 16'h0100, 1'b1, 1'b0);

      // random traffic over short vectors of a few shared lengths
      start_cnt = sent;
      while (sent - start_cnt < 140) begin
         calm = (sent - start_cnt) > 40 && (sent - start_cnt) < 90;
         len  = $urandom_range(3) == 0 ? $urandom_range(8) : 1 + $urandom_range(3);
         pick = $urandom_range(99);
         if (stored >= 40 || pick < 4) clear_store();
         else if (pick < 50) send_vec(OP_ENTRY, len, $urandom_range(4) == 0 ? 1 : 0);
         else if (pick < 58) send_vec(OP_ENTRY, saved_len, 2);
         else if (pick < 82) send_vec(OP_QUERY, len, $urandom_range(1));
         else if (pick < 88) send_vec(OP_QUERY, saved_len, 2 + $urandom_range(1));
         else if (pick < 91) send_vec(OP_QUERY, len, 4);
         else if (pick < 94) begin
            // broken sequence: partial vector abandoned by a switch of kind
            send_word($urandom_range(1) ? OP_ENTRY : OP_QUERY, 16'($urandom), 1'b0, 1'b0);
            send_vec($urandom_range(1) ? OP_ENTRY : OP_QUERY, len, 0);
         end else if (pick < 97) send_word(OP_NONE, 16'($urandom), 1'($urandom), 1'($urandom));
         else write_top_k($urandom_range(2) == 0 ? 5'($urandom) : 5'($urandom_range(1, 16)));
      end
      calm = 1'b0;

      // fill the store past capacity while the receiver holds off
      write_top_k(5'd16);
      clear_store();
      hold_asks++;
      for (int i = 0; i < MAX_ENTRIES + 2; i++)
         send_word(OP_ENTRY, $urandom_range(3) == 0 ? 16'($urandom) : 16'h0040, 1'b1, 1'b0);
      send_word(OP_QUERY, 16'h0200, 1'b1, 1'b0);
      send_word(OP_QUERY, 16'hfe00, 1'b1, 1'b0);
      req_valid <= 1'b0;

      // drain
      drain = 0;
      while (outstanding != 0) @(posedge clock);
      while (drain < 200) begin
         @(posedge clock);
         drain++;
      end
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire
